>>> rtl/dq_pkg.sv
package dq_pkg;

    localparam int DATA_W   = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 5;

    typedef logic signed [DATA_W-1:0] value_t;
    typedef logic [REQ_W-1:0]         req_type_t;
    typedef logic [STATUS_W-1:0]      status_t;
    typedef logic [TOTAL_W-1:0]       total_t;

    // Request codes
    localparam req_type_t REQ_PUSH_FRONT = 2'd0;
    localparam req_type_t REQ_PUSH_BACK  = 2'd1;
    localparam req_type_t REQ_POP_FRONT  = 2'd2;
    localparam req_type_t REQ_POP_BACK   = 2'd3;

    // Status codes
    localparam status_t ST_DONE      = 2'd0;
    localparam status_t ST_POP_EMPTY = 2'd1;
    localparam status_t ST_PUSH_FULL = 2'd2;

endpackage

>>> rtl/dq_if.sv
interface dq_req_if;
    logic                 valid;
    logic                 ready;
    dq_pkg::req_type_t    req_type;
    dq_pkg::value_t       push_value;

    modport source (output valid, output req_type, output push_value, input ready);
    modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface dq_rsp_if;
    logic                 valid;
    logic                 ready;
    dq_pkg::status_t      status;
    dq_pkg::total_t       entry_total;
    logic                 is_empty;
    dq_pkg::value_t       front_value;
    dq_pkg::value_t       back_value;

    modport source (output valid, output status, output entry_total, output is_empty,
                    output front_value, output back_value, input ready);
    modport sink   (input valid, input status, input entry_total, input is_empty,
                    input front_value, input back_value, output ready);
endinterface

>>> rtl/dq_ring.sv
module dq_ring #(
    parameter int DEPTH = 16,
    parameter int IW    = 4
) (
    input  logic           clk,
    input  logic           wr_en,
    input  logic [IW-1:0]  wr_addr,
    input  dq_pkg::value_t wr_data,
    input  logic           rd_en,
    input  logic [IW-1:0]  rd_addr_a,
    input  logic [IW-1:0]  rd_addr_b,
    output dq_pkg::value_t rd_data_a,
    output dq_pkg::value_t rd_data_b
);
    import dq_pkg::*;

    value_t mem [DEPTH];
    value_t rd_a_reg;
    value_t rd_b_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read two entries, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

>>> rtl/double_ended_queue.sv
// Channel | Dir | Fields                                                    | Handshake
// req     | in  | req_type, push_value                                      | valid/ready
// rsp     | out | status, entry_total, is_empty, front_value, back_value    | valid/ready
//
// Each request passes through these steps: index update and write, a registered read of the
// front and back entries from the ring memory, then the load of the result register.
// The single ring memory with its registered read sets these steps.
// Reset (rst_n low) clears head, count, state and the result valid; the memory is not cleared.
// A new request is taken while a finished result still waits in the result register;
// the next result waits in the load step until the previous one is taken.
module double_ended_queue #(
    parameter int CAPACITY = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    dq_req_if.sink    req,
    dq_rsp_if.source  rsp
);
    import dq_pkg::*;

    localparam int IW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = IW + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    status_t       status_reg, status_next;

    logic          rsp_valid_reg, rsp_valid_next;
    status_t       rsp_status_reg, rsp_status_next;
    total_t        rsp_total_reg, rsp_total_next;
    logic          rsp_empty_reg, rsp_empty_next;
    value_t        rsp_front_reg, rsp_front_next;
    value_t        rsp_back_reg, rsp_back_next;

    logic          accept;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] head_dec;
    logic [IW-1:0] head_inc;
    logic [SW-1:0] tail_sum;
    logic [IW-1:0] tail_addr;
    logic [SW-1:0] back_sum;
    logic [IW-1:0] back_addr;
    logic          rd_en;
    value_t        front_rd;
    value_t        back_rd;
    logic          is_full;
    logic          is_zero;

    assign accept  = req.valid && req.ready;
    assign is_full = (count_reg >= CW'(CAPACITY));
    assign is_zero = (count_reg == '0);

    // Wrap the head one step either way
    assign head_dec = (head_reg == '0) ? IW'(CAPACITY - 1) : head_reg - IW'(1);
    assign head_inc = (head_reg == IW'(CAPACITY - 1)) ? '0 : head_reg + IW'(1);

    // Slot behind the last entry
    assign tail_sum  = SW'(head_reg) + SW'(count_reg);
    assign tail_addr = (tail_sum >= SW'(CAPACITY)) ? IW'(tail_sum - SW'(CAPACITY))
                                                   : IW'(tail_sum);

    // Last entry after the update
    assign back_sum  = is_zero ? '0 : SW'(head_reg) + SW'(count_reg) - SW'(1);
    assign back_addr = (back_sum >= SW'(CAPACITY)) ? IW'(back_sum - SW'(CAPACITY))
                                                   : IW'(back_sum);

    assign rd_en = (state_reg == S_READ);

    // Update indices and count for an accepted transaction
    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = tail_addr;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next  = S_READ;
                    status_next = ST_DONE;
                    case (req.req_type)
                        REQ_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_PUSH_FULL;
                            end
                            else
                            begin
                                head_next  = head_dec;
                                count_next = count_reg + CW'(1);
                                wr_en      = 1'b1;
                                wr_addr    = head_dec;
                            end
                        end
                        REQ_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_PUSH_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                                wr_en      = 1'b1;
                                wr_addr    = tail_addr;
                            end
                        end
                        REQ_POP_FRONT:
                        begin
                            if (is_zero)
                            begin
                                status_next = ST_POP_EMPTY;
                            end
                            else
                            begin
                                head_next  = head_inc;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        REQ_POP_BACK:
                        begin
                            if (is_zero)
                            begin
                                status_next = ST_POP_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        default:
                        begin
                            status_next = ST_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Load the result register and drop it once taken
    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_total_next  = rsp_total_reg;
        rsp_empty_next  = rsp_empty_reg;
        rsp_front_next  = rsp_front_reg;
        rsp_back_next   = rsp_back_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if ((state_reg == S_LOAD) && (!rsp_valid_reg || rsp.ready))
        begin
            rsp_valid_next  = 1'b1;
            rsp_status_next = status_reg;
            rsp_total_next  = TOTAL_W'(count_reg);
            rsp_empty_next  = is_zero;
            rsp_front_next  = is_zero ? '0 : front_rd;
            rsp_back_next   = is_zero ? '0 : back_rd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        rsp_status_reg <= rsp_status_next;
        rsp_total_reg  <= rsp_total_next;
        rsp_empty_reg  <= rsp_empty_next;
        rsp_front_reg  <= rsp_front_next;
        rsp_back_reg   <= rsp_back_next;
    end

    dq_ring #(
        .DEPTH (CAPACITY),
        .IW    (IW)
    ) u_ring (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (req.push_value),
        .rd_en     (rd_en),
        .rd_addr_a (head_reg),
        .rd_addr_b (back_addr),
        .rd_data_a (front_rd),
        .rd_data_b (back_rd)
    );

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.entry_total = rsp_total_reg;
    assign rsp.is_empty    = rsp_empty_reg;
    assign rsp.front_value = rsp_front_reg;
    assign rsp.back_value  = rsp_back_reg;

endmodule

>>> rtl/dq_checker.sv
module dq_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rsp_valid,
    input  logic            rsp_ready,
    input  dq_pkg::status_t rsp_status,
    input  dq_pkg::total_t  rsp_total,
    input  logic            rsp_empty,
    input  dq_pkg::value_t  rsp_front,
    input  dq_pkg::value_t  rsp_back
);
    import dq_pkg::*;

    // An ignored pop leaves nothing stored
    a_pop_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status == ST_POP_EMPTY)) |-> (rsp_empty && (rsp_total == '0)))
        else $error("pop on empty reported with entries");

    // A dropped push means a full, non-empty queue
    a_push_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status == ST_PUSH_FULL)) |-> !rsp_empty)
        else $error("push on full reported with empty queue");

    // An empty queue shows zero at both ends
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_empty) |-> ((rsp_front == '0) && (rsp_back == '0)))
        else $error("empty queue with nonzero end values");

    // A non-empty count never claims empty
    a_total_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_total != '0)) |-> !rsp_empty)
        else $error("nonzero count flagged empty");

    // A stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("result withdrawn before taken");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_total  (rsp.entry_total),
    .rsp_empty  (rsp.is_empty),
    .rsp_front  (rsp.front_value),
    .rsp_back   (rsp.back_value)
);
